[src/keypad_debounce_autorepeat_macros.svh]
// Assertion macros shared by the keypad debounce checker.
`ifndef KEYPAD_DEBOUNCE_AUTOREPEAT_MACROS_SVH
`define KEYPAD_DEBOUNCE_AUTOREPEAT_MACROS_SVH

// Implication checked every clock edge outside reset.
`define KDA_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked every clock edge outside reset.
`define KDA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[src/kda_pkg.sv]
// Shared constants, types and register codes of the keypad debounce block.
`timescale 1ns / 1ps

package kda_pkg;

	localparam int NUM_KEYS       = 7;
	localparam int FILTER_SAMPLES = 8;

	localparam int KEY_W  = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
	localparam int FC_W   = (FILTER_SAMPLES > 1) ? $clog2(FILTER_SAMPLES) : 1;
	localparam int CNT_W  = 16;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [FC_W-1:0]  FILTER_TOP = FC_W'(FILTER_SAMPLES - 1);
	localparam logic [KEY_W-1:0] LAST_KEY   = KEY_W'(NUM_KEYS - 1);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIRST_DELAY = 2'd0,
		REG_INTERVAL    = 2'd1,
		REG_ENABLE_MASK = 2'd2
	} cfg_reg_t;

	// Per-key state word held in the state RAM.
	typedef struct packed {
		logic             level;
		logic [FC_W-1:0]  filter;
		logic [CNT_W-1:0] hold;
		logic [CNT_W-1:0] rep;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

[src/kda_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module kda_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

[src/kda_key_unit.sv]
// Per-key update: integrating filter, press edge and auto-repeat counters.
`timescale 1ns / 1ps

module kda_key_unit (
	input  kda_pkg::entry_t                cur,
	input  logic                           raw_bit,
	input  logic                           rep_en,
	input  logic [kda_pkg::CNT_W-1:0]      first_delay,
	input  logic [kda_pkg::CNT_W-1:0]      interval,
	output kda_pkg::entry_t                nxt,
	output logic                           event_bit
);

	always_comb begin
		nxt = cur;
		// integrate the raw sample, saturate at both ends
		if (raw_bit) begin
			if (cur.filter < kda_pkg::FILTER_TOP) begin
				nxt.filter = cur.filter + 1'b1;
			end else begin
				nxt.level = 1'b1;
			end
		end else begin
			if (cur.filter != '0) begin
				nxt.filter = cur.filter - 1'b1;
			end else begin
				nxt.level = 1'b0;
			end
		end

		event_bit = !cur.level && nxt.level;

		if (rep_en) begin
			if (nxt.level) begin
				if (cur.hold < first_delay) begin
					nxt.hold = cur.hold + 1'b1;
				end else if (cur.rep < interval) begin
					nxt.rep = cur.rep + 1'b1;
				end else begin
					event_bit = 1'b1;
					nxt.rep   = '0;
				end
			end else begin
				nxt.hold = '0;
				nxt.rep  = '0;
			end
		end
	end

endmodule

[src/keypad_debounce_autorepeat.sv]
// Top level of the keypad debounce and auto-repeat block.
`timescale 1ns / 1ps

// Keypad debounce with auto-repeat. Each raw_keys word is one sampling tick;
// every tick returns one result word with the key events (press edges and
// auto-repeat events) and the filtered key levels. All per-key state
// (filter count, debounced level, hold and repeat counters) lives in one
// small state RAM with a registered read. A sequencer walks the keys one
// per cycle unless the pipeline holds: read the entry, update it, write it
// back. Each tick uses the single RAM read port once per key, and ticks
// follow each other without gaps. The result sits in an output register,
// so the next tick is processed while a result waits; only when a second
// result is ready and the first has not been taken does the pipeline hold.
// Per-entry valid bits stand in for a reset of the RAM, so there is no
// clearing pass. Configuration: index 0 first repeat delay, 1 repeat
// interval, 2 repeat enable mask; other indexes are dropped.
// The configuration port is always ready; write it only while idle.
module keypad_debounce_autorepeat (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// configuration write channel
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [kda_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [kda_pkg::CFG_DATA_W-1:0]        cfg_data,
	// tick input channel
	input  logic                                  raw_valid,
	output logic                                  raw_ready,
	input  logic [kda_pkg::NUM_KEYS-1:0]          raw_keys,
	// result channel
	output logic                                  res_valid,
	input  logic                                  res_ready,
	output logic [kda_pkg::NUM_KEYS-1:0]          key_events,
	output logic [kda_pkg::NUM_KEYS-1:0]          debounced_keys
);

	localparam int NK = kda_pkg::NUM_KEYS;
	localparam int KW = kda_pkg::KEY_W;

	// configuration registers
	logic [kda_pkg::CNT_W-1:0] first_delay_q;
	logic [kda_pkg::CNT_W-1:0] interval_q;
	logic [NK-1:0]             enable_mask_q;

	// sequencer
	logic          busy_q;
	logic [KW-1:0] key_q;
	logic [NK-1:0] raw_q;
	logic          issue;
	logic          last_issue;
	logic          stall;
	logic          raw_take;

	// update stage
	logic          valid_s1;
	logic [KW-1:0] key_s1;
	logic          raw_s1;
	logic          vld_s1;
	logic          fwd_hit_s1;
	kda_pkg::entry_t fwd_data_s1;

	// state RAM ports
	logic          wr_en;
	logic [kda_pkg::ENTRY_W-1:0] rd_word;
	kda_pkg::entry_t cur_entry;
	kda_pkg::entry_t nxt_entry;
	logic          event_bit;
	logic [NK-1:0] entry_valid_q;

	// accumulators for the tick in flight
	logic [NK-1:0] acc_ev_q;
	logic [NK-1:0] acc_lv_q;
	logic [NK-1:0] acc_ev_next;
	logic [NK-1:0] acc_lv_next;
	logic [NK-1:0] key_bit;

	logic          res_valid_q;
	logic [NK-1:0] key_events_q;
	logic [NK-1:0] debounced_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_delay_q <= '0;
			interval_q    <= '0;
			enable_mask_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				kda_pkg::REG_FIRST_DELAY: first_delay_q <= cfg_data;
				kda_pkg::REG_INTERVAL:    interval_q    <= cfg_data;
				kda_pkg::REG_ENABLE_MASK: enable_mask_q <= cfg_data[NK-1:0];
				default: ;
			endcase
		end
	end

	// Hold everything when a finished word cannot be handed to the output.
	assign stall      = valid_s1 && (key_s1 == kda_pkg::LAST_KEY) &&
	                    res_valid_q && !res_ready;
	assign issue      = busy_q && !stall;
	assign last_issue = issue && (key_q == kda_pkg::LAST_KEY);
	assign raw_ready  = !busy_q || last_issue;
	assign raw_take   = raw_valid && raw_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			key_q  <= '0;
		end else begin
			if (raw_take) begin
				busy_q <= 1'b1;
				key_q  <= '0;
			end else if (last_issue) begin
				busy_q <= 1'b0;
				key_q  <= '0;
			end else if (issue) begin
				key_q <= key_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (raw_take) begin
			raw_q <= raw_keys;
		end
	end

	// Advance the read into the update stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			key_s1      <= key_q;
			raw_s1      <= raw_q[key_q];
			vld_s1      <= entry_valid_q[key_q];
			// the entry being written now is not yet seen by the RAM read
			fwd_hit_s1  <= wr_en && (key_s1 == key_q);
			fwd_data_s1 <= nxt_entry;
		end
	end

	kda_ram #(
		.WIDTH (kda_pkg::ENTRY_W),
		.DEPTH (NK)
	) u_state_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (key_s1),
		.wr_data (nxt_entry),
		.rd_en   (issue),
		.rd_addr (key_q),
		.rd_data (rd_word)
	);

	// Pick forwarded data, else RAM data; a never-written entry reads as zero.
	always_comb begin
		if (fwd_hit_s1) begin
			cur_entry = fwd_data_s1;
		end else if (vld_s1) begin
			cur_entry = kda_pkg::entry_t'(rd_word);
		end else begin
			cur_entry = '0;
		end
	end

	kda_key_unit u_key_unit (
		.cur         (cur_entry),
		.raw_bit     (raw_s1),
		.rep_en      (enable_mask_q[key_s1]),
		.first_delay (first_delay_q),
		.interval    (interval_q),
		.nxt         (nxt_entry),
		.event_bit   (event_bit)
	);

	assign wr_en = valid_s1 && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
		end else if (wr_en) begin
			entry_valid_q[key_s1] <= 1'b1;
		end
	end

	// Collect this key's bits into the word of the tick.
	always_comb begin
		key_bit = '0;
		key_bit[key_s1] = 1'b1;
		if (key_s1 == '0) begin
			acc_ev_next = '0;
			acc_lv_next = '0;
		end else begin
			acc_ev_next = acc_ev_q;
			acc_lv_next = acc_lv_q;
		end
		if (event_bit) begin
			acc_ev_next = acc_ev_next | key_bit;
		end
		if (nxt_entry.level) begin
			acc_lv_next = acc_lv_next | key_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			acc_ev_q <= acc_ev_next;
			acc_lv_q <= acc_lv_next;
		end
	end

	// Output register: load the finished word, drop valid once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (wr_en && (key_s1 == kda_pkg::LAST_KEY)) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en && (key_s1 == kda_pkg::LAST_KEY)) begin
			key_events_q <= acc_ev_next;
			debounced_q  <= acc_lv_next;
		end
	end

	assign res_valid      = res_valid_q;
	assign key_events     = key_events_q;
	assign debounced_keys = debounced_q;

endmodule

[src/kda_checker.sv]
// Port-level checker for the keypad debounce block, with its bind.
`timescale 1ns / 1ps
`include "keypad_debounce_autorepeat_macros.svh"

module kda_port_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  cfg_valid,
	input logic                                  cfg_ready,
	input logic                                  res_valid,
	input logic                                  res_ready,
	input logic [kda_pkg::NUM_KEYS-1:0]          key_events,
	input logic [kda_pkg::NUM_KEYS-1:0]          debounced_keys
);

	// a stalled result word stays offered
	`KDA_ASSERT_NEXT(a_res_hold, res_valid && !res_ready, res_valid, "result word dropped")

	// a stalled result word keeps its payload
	`KDA_ASSERT_NEXT(a_res_stable, res_valid && !res_ready, $stable(key_events) && $stable(debounced_keys), "result word changed while stalled")

	// an event only fires on a key that is filtered high
	`KDA_ASSERT_IMP(a_event_level, res_valid, (key_events & ~debounced_keys) == '0, "event on a released key")

	// configuration writes are never held off
	`KDA_ASSERT_IMP(a_cfg_ready, cfg_valid, cfg_ready, "configuration write stalled")

endmodule

bind keypad_debounce_autorepeat kda_port_checker u_kda_port_checker (.*);
